>>> sv/gclcp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the G-code line checksum preprocessor.
// No dependencies; used by every module of the block.
package gclcp_pkg;

  // Line parser mode, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_SUM    = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_PAREN  = 5'b01000,
    MODE_SEMI   = 5'b10000
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  localparam int LEN_W  = 7;
  localparam int CHAR_W = 8;
  localparam int NUM_W  = 31;

  typedef struct packed {
    kind_t                  kind;
    logic [CHAR_W-1:0]      out_char;
    logic [LEN_W-1:0]       line_length;
    logic signed [31:0]     mismatch_line;
  } result_t;

  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_B      = 8'h42;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_LC_N   = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;

  localparam logic [NUM_W-1:0]  NUMBER_MAX = 31'h7FFF_FFFF;
  localparam logic signed [31:0] NO_LINE   = -32'sd1;

endpackage

>>> sv/gcode_line_checksum_preprocessor_unit.sv
`timescale 1ns / 1ps
// Top level of the G-code line checksum preprocessor: input register,
// line state update and result register. Depends on gclcp_pkg, gclcp_line_ctrl, gclcp_out_reg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_stall  | in_byte
//   output  | out_valid / out_stall| kind, out_char, line_length, mismatch_line
//
// One byte per cycle sustained while the output is not stalled; a result is
// presented once its byte has passed the input register and then the result
// register; the update of the line state between them is combinational.
// Reset (rst, synchronous) empties both registers and clears the line state.
// A stalled result holds the input register, which then stalls the input;
// bytes that give no result pass through even while a result waits.
module gcode_line_checksum_preprocessor_unit #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [7:0]          out_char,
  output logic [6:0]          line_length,
  output logic signed [31:0]  mismatch_line
);

  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               advance;
  logic               out_ready;
  logic               res_valid;
  gclcp_pkg::result_t res;
  gclcp_pkg::result_t held;

  // a byte with no result may move on even while the output is stalled
  assign advance  = s1_valid && (out_ready || !res_valid);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= in_byte;
    end
  end

  gclcp_line_ctrl #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step_en  (advance),
    .in_byte  (s1_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  gclcp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .ready    (out_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .held     (held)
  );

  assign kind          = held.kind;
  assign out_char      = held.out_char;
  assign line_length   = held.line_length;
  assign mismatch_line = held.mismatch_line;

endmodule

>>> sv/gclcp_line_ctrl.sv
`timescale 1ns / 1ps
// Line state registers and the per-byte update: comment stripping, checksum,
// line-number capture and character storage. Depends on gclcp_pkg.
module gclcp_line_ctrl #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step_en,
  input  logic [7:0]                in_byte,
  output logic                      res_valid,
  output gclcp_pkg::result_t        res
);

  localparam int CW = $clog2(LINE_CAPACITY);
  localparam logic [CW-1:0] CNT_LIMIT = CW'(LINE_CAPACITY - 1);

  gclcp_pkg::mode_t mode, mode_next;
  logic [CW-1:0]    char_count, char_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic             has_sum, has_sum_next;
  logic [7:0]       expected_sum, expected_sum_next;
  logic             has_number, has_number_next;
  logic [gclcp_pkg::NUM_W-1:0] number_value, number_value_next;
  logic             dot_seen, dot_seen_next;
  logic             first_is_b, first_is_b_next;

  logic             eol;
  logic             digit;
  logic [3:0]       digit_val;
  logic             full;
  logic [CW-1:0]    store_count;
  logic [34:0]      num_wide;

  function automatic logic [gclcp_pkg::LEN_W-1:0] LEN_W_CAST(input logic [CW-1:0] cnt);
    LEN_W_CAST = gclcp_pkg::LEN_W'(cnt);
  endfunction

  always_comb begin
    eol         = (in_byte == gclcp_pkg::CH_LF) || (in_byte == gclcp_pkg::CH_CR);
    digit       = in_byte inside {[gclcp_pkg::CH_0 : gclcp_pkg::CH_9]};
    digit_val   = in_byte[3:0];
    full        = (char_count >= CNT_LIMIT);
    store_count = char_count + 1'b1;
    num_wide    = ({4'b0, number_value} << 3) + ({4'b0, number_value} << 1)
                  + {31'b0, digit_val};
  end

  always_comb begin
    logic       fall;
    logic       do_store;
    logic       do_clear;
    logic [7:0] st_char;

    mode_next         = mode;
    char_count_next   = char_count;
    running_xor_next  = running_xor;
    has_sum_next      = has_sum;
    expected_sum_next = expected_sum;
    has_number_next   = has_number;
    number_value_next = number_value;
    dot_seen_next     = dot_seen;
    first_is_b_next   = first_is_b;
    res_valid         = 1'b0;
    res               = '0;
    fall              = 1'b1;
    do_store          = 1'b0;
    do_clear          = 1'b0;
    st_char           = in_byte;

    if (eol) begin
      res_valid       = 1'b1;
      res.line_length = LEN_W_CAST(char_count);
      if (has_sum && (expected_sum != running_xor)) begin
        res.kind          = gclcp_pkg::KIND_MISMATCH;
        res.mismatch_line = has_number ? $signed({1'b0, number_value})
                                       : gclcp_pkg::NO_LINE;
      end else begin
        res.kind = gclcp_pkg::KIND_LINE;
      end
      do_clear = 1'b1;
      fall     = 1'b0;
    end else if (mode == gclcp_pkg::MODE_SUM) begin
      if (digit) begin
        has_sum_next      = 1'b1;
        expected_sum_next = (expected_sum << 3) + (expected_sum << 1) + {4'b0, digit_val};
        fall              = 1'b0;
      end else begin
        mode_next = gclcp_pkg::MODE_NORMAL;
      end
    end else if (mode == gclcp_pkg::MODE_NUMBER) begin
      if (digit || (in_byte == gclcp_pkg::CH_DOT)) begin
        fall = 1'b0;
        if (full) begin
          res_valid       = 1'b1;
          res.kind        = gclcp_pkg::KIND_OVERFLOW;
          res.line_length = LEN_W_CAST(char_count);
          do_clear        = 1'b1;
        end else begin
          has_number_next = 1'b1;
          if (!digit) begin
            dot_seen_next = 1'b1;
          end else if (!dot_seen) begin
            if (num_wide > {4'b0, gclcp_pkg::NUMBER_MAX}) begin
              number_value_next = gclcp_pkg::NUMBER_MAX;
            end else begin
              number_value_next = num_wide[gclcp_pkg::NUM_W-1:0];
            end
          end
          running_xor_next = running_xor ^ in_byte;
          do_store         = 1'b1;
        end
      end else begin
        mode_next = gclcp_pkg::MODE_NORMAL;
      end
    end

    if (fall) begin
      if ((mode_next == gclcp_pkg::MODE_PAREN) || (mode_next == gclcp_pkg::MODE_SEMI)) begin
        if ((in_byte == gclcp_pkg::CH_RPAREN) && (mode_next == gclcp_pkg::MODE_PAREN)) begin
          mode_next = gclcp_pkg::MODE_NORMAL;
        end
      end else if (in_byte == gclcp_pkg::CH_STAR) begin
        mode_next = gclcp_pkg::MODE_SUM;
      end else if (in_byte <= gclcp_pkg::CH_SPACE) begin
        running_xor_next = running_xor ^ in_byte;
      end else if (in_byte == gclcp_pkg::CH_LPAREN) begin
        mode_next = gclcp_pkg::MODE_PAREN;
      end else if (in_byte == gclcp_pkg::CH_SEMI) begin
        mode_next = gclcp_pkg::MODE_SEMI;
      end else if (full) begin
        res_valid       = 1'b1;
        res.kind        = gclcp_pkg::KIND_OVERFLOW;
        res.line_length = LEN_W_CAST(char_count);
        do_clear        = 1'b1;
      end else begin
        if ((char_count == '0) &&
            ((in_byte == gclcp_pkg::CH_N) || (in_byte == gclcp_pkg::CH_LC_N))) begin
          mode_next = gclcp_pkg::MODE_NUMBER;
        end
        running_xor_next = running_xor ^ in_byte;
        // upper-case unless this is a later character of a B line
        if ((in_byte inside {[gclcp_pkg::CH_LC_A : gclcp_pkg::CH_LC_Z]}) &&
            !((char_count != '0) && first_is_b)) begin
          st_char = in_byte - gclcp_pkg::CASE_GAP;
        end
        do_store = 1'b1;
      end
    end

    if (do_store) begin
      if ((char_count == '0) && (st_char == gclcp_pkg::CH_B)) begin
        first_is_b_next = 1'b1;
      end
      char_count_next = store_count;
      res_valid       = 1'b1;
      res.kind        = gclcp_pkg::KIND_CHAR;
      res.out_char    = st_char;
      res.line_length = LEN_W_CAST(store_count);
    end

    if (do_clear) begin
      mode_next         = gclcp_pkg::MODE_NORMAL;
      char_count_next   = '0;
      running_xor_next  = '0;
      has_sum_next      = 1'b0;
      expected_sum_next = '0;
      has_number_next   = 1'b0;
      number_value_next = '0;
      dot_seen_next     = 1'b0;
      first_is_b_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= gclcp_pkg::MODE_NORMAL;
      char_count   <= '0;
      running_xor  <= '0;
      has_sum      <= 1'b0;
      expected_sum <= '0;
      has_number   <= 1'b0;
      number_value <= '0;
      dot_seen     <= 1'b0;
      first_is_b   <= 1'b0;
    end else if (step_en) begin
      mode         <= mode_next;
      char_count   <= char_count_next;
      running_xor  <= running_xor_next;
      has_sum      <= has_sum_next;
      expected_sum <= expected_sum_next;
      has_number   <= has_number_next;
      number_value <= number_value_next;
      dot_seen     <= dot_seen_next;
      first_is_b   <= first_is_b_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= CNT_LIMIT)
    else $error("line character count beyond capacity");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (step_en && eol) |=> ((char_count == '0) && (mode == gclcp_pkg::MODE_NORMAL)))
    else $error("line state not cleared after end of line");

  a_number_flag: assert property (@(posedge clk) disable iff (rst)
    !has_number |-> (number_value == '0))
    else $error("line number value without captured number");

  a_b_line_nonempty: assert property (@(posedge clk) disable iff (rst)
    first_is_b |-> (char_count != '0))
    else $error("B line flag set on empty line");

endmodule

>>> sv/gclcp_out_reg.sv
`timescale 1ns / 1ps
// Result register for the preprocessor: holds one result transaction until
// the downstream side takes it. Depends on gclcp_pkg.
module gclcp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  gclcp_pkg::result_t   res,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gclcp_pkg::result_t   held
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  // payload needs no reset; update only when the register is free
  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= res;
    end
  end

endmodule
